>>> hw/rtl/dual_sine_oscillator_mixer_defines.svh
// ----------------------------------------------------------------------------
// Dual sine oscillator mixer: assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef DUAL_SINE_OSCILLATOR_MIXER_DEFINES_SVH
`define DUAL_SINE_OSCILLATOR_MIXER_DEFINES_SVH

// Checked outside reset.
`define DSOM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define DSOM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/dsom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsom_pkg
// Shared constants, register indexes and control types of the mixer.
// ----------------------------------------------------------------------------
package dsom_pkg;

  localparam int CHANNELS_DEF         = 2;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;

  localparam int STEP_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP_ONE = 8'd0,
    CFG_PHASE_STEP_TWO = 8'd1,
    CFG_GAIN_ONE       = 8'd2,
    CFG_GAIN_TWO       = 8'd3
  } dsom_cfg_idx_t;

  // phase accumulator control from the pipeline
  typedef struct packed {
    logic load;    // read the phase entry of a newly accepted beat
    logic commit;  // write back the advanced phases of the stage-1 beat
  } dsom_ph_ctl_t;

endpackage

>>> hw/rtl/dsom_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsom_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dsom_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/dsom_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsom_sine_rom
// Quarter-wave sine table, two registered read ports, built at elaboration.
// ----------------------------------------------------------------------------
module dsom_sine_rom #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [AW-1:0]                 addr_a,
  input  logic [AW-1:0]                 addr_b,
  output logic [dsom_pkg::SAMPLE_W-1:0] q_a,
  output logic [dsom_pkg::SAMPLE_W-1:0] q_b
);
  import dsom_pkg::*;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Entry i: sine at the middle of slot i, fixed-point odd series.
  // The slot width divides by 4*DEPTH, a power of two, hence the shift.
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned shift);
    logic [63:0] x;
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] s;
    x   = (64'(2 * idx + 1) * PI_Q30) >> shift;
    sq  = (x * x) >> 30;
    acc = Q30_ONE;
    acc = Q30_ONE - ((sq * acc) >> 30) / 64'd156;
    acc = Q30_ONE - ((sq * acc) >> 30) / 64'd110;
    acc = Q30_ONE - ((sq * acc) >> 30) / 64'd72;
    acc = Q30_ONE - ((sq * acc) >> 30) / 64'd42;
    acc = Q30_ONE - ((sq * acc) >> 30) / 64'd20;
    acc = Q30_ONE - ((sq * acc) >> 30) / 64'd6;
    s   = (x * acc) >> 30;
    sine_entry = SAMPLE_W'((s * 64'd32767 + (64'd1 << 29)) >> 30);
  endfunction

  logic [SAMPLE_W-1:0] tab [DEPTH];
  logic [SAMPLE_W-1:0] q_a_r;
  logic [SAMPLE_W-1:0] q_b_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(g, AW + 2);
    assign tab[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_a_r <= tab[addr_a];
      q_b_r <= tab[addr_b];
    end
  end

  assign q_a = q_a_r;
  assign q_b = q_b_r;

endmodule

>>> hw/rtl/dsom_phase_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsom_phase_acc
// Per-channel phase pair in RAM: read on accept, advance, write back, with
// forwarding of a write-back to the same channel read in the same cycle.
// ----------------------------------------------------------------------------
`include "dual_sine_oscillator_mixer_defines.svh"

module dsom_phase_acc #(
  parameter int CHANNELS   = dsom_pkg::CHANNELS_DEF,
  parameter int PHASE_BITS = dsom_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dsom_pkg::dsom_ph_ctl_t      ctl,
  input  logic                        channel,
  input  logic [dsom_pkg::STEP_W-1:0] phase_step_one,
  input  logic [dsom_pkg::STEP_W-1:0] phase_step_two,
  output logic [PHASE_BITS-1:0]       phase_one,
  output logic [PHASE_BITS-1:0]       phase_two
);
  import dsom_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = PHASE_BITS;

  logic [CH_W-1:0]     ch_addr;
  logic [2*PW-1:0]     ram_q;
  logic [2*PW-1:0]     cur;
  logic [PW-1:0]       adv_one;
  logic [PW-1:0]       adv_two;

  logic [CH_W-1:0]     addr_r;
  logic                fwd_r;
  logic                fwd_nxt;
  logic [2*PW-1:0]     fwd_data_r;
  logic                hit_r;
  logic                hit_nxt;
  logic [CHANNELS-1:0] vld_r;
  logic [CHANNELS-1:0] vld_nxt;

  assign ch_addr = CH_W'(channel);

  dsom_ram #(
    .WIDTH (2 * PW),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.commit),
    .waddr (addr_r),
    .wdata ({adv_two, adv_one}),
    .re    (ctl.load),
    .raddr (ch_addr),
    .rdata (ram_q)
  );

  // an entry never written reads as zero
  assign cur     = fwd_r ? fwd_data_r : (hit_r ? ram_q : '0);
  assign adv_one = cur[PW-1:0]    + PW'(phase_step_one);
  assign adv_two = cur[2*PW-1:PW] + PW'(phase_step_two);

  assign phase_one = cur[PW-1:0];
  assign phase_two = cur[2*PW-1:PW];

  always_comb begin
    fwd_nxt = fwd_r;
    hit_nxt = hit_r;
    vld_nxt = vld_r;
    if (ctl.load) begin
      // RAM read at this edge misses a write-back at the same edge
      fwd_nxt = ctl.commit && (addr_r == ch_addr);
      hit_nxt = (32'(ch_addr) < CHANNELS) && vld_r[ch_addr];
    end
    if (ctl.commit) begin
      vld_nxt[addr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
      hit_r <= 1'b0;
      vld_r <= '0;
    end else begin
      fwd_r <= fwd_nxt;
      hit_r <= hit_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addr_r     <= ch_addr;
      fwd_data_r <= {adv_two, adv_one};
    end
  end

  `DSOM_ASSERT(a_fwd_same_entry, (ctl.load && ctl.commit && addr_r == ch_addr) |=> fwd_r, "same-channel write-back not forwarded")
  `DSOM_ASSERT(a_commit_marks_valid, ctl.commit |=> vld_r[$past(addr_r)], "written entry not marked valid")
  `DSOM_ASSERT_RST(a_reset_clears, !rst_n |=> (vld_r == '0 && !fwd_r && !hit_r), "reset left phase state valid")

endmodule

>>> hw/rtl/dual_sine_oscillator_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_sine_oscillator_mixer
// Two-tone sine generator: per-channel phase pair, quarter-wave lookup,
// gain, rounded and saturated sum.
// ----------------------------------------------------------------------------
// Pipeline: phase RAM read, table read, gain product, then the output register.
// Throughput: one beat per cycle absent output backpressure; a channel's phase
//   RAM read-modify-write is forwarded, so it may be requested in consecutive cycles.
// Reset: clears the configuration registers, pipeline valids and the phase
//   valid bits, so all phases read as zero until first written.
// SINE_TABLE_DEPTH must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "dual_sine_oscillator_mixer_defines.svh"

module dual_sine_oscillator_mixer #(
  parameter int CHANNELS         = dsom_pkg::CHANNELS_DEF,
  parameter int SINE_TABLE_DEPTH = dsom_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = dsom_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dsom_pkg::IN_TDATA_W-1:0] in_tdata,   // [0] channel
  // output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dsom_pkg::SAMPLE_W-1:0]   out_tdata,  // [15:0] sample_out
  output logic [0:0]                      out_tuser,  // [0] clipped
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsom_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dsom_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = PHASE_BITS;

  // configuration
  logic [STEP_W-1:0] step_one_r, step_one_nxt;
  logic [STEP_W-1:0] step_two_r, step_two_nxt;
  logic [GAIN_W-1:0] gain_one_r, gain_one_nxt;
  logic [GAIN_W-1:0] gain_two_r, gain_two_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    step_one_nxt = step_one_r;
    step_two_nxt = step_two_r;
    gain_one_nxt = gain_one_r;
    gain_two_nxt = gain_two_r;
    if (cfg_valid) begin
      case (dsom_cfg_idx_t'(cfg_index))
        CFG_PHASE_STEP_ONE: step_one_nxt = cfg_data[STEP_W-1:0];
        CFG_PHASE_STEP_TWO: step_two_nxt = cfg_data[STEP_W-1:0];
        CFG_GAIN_ONE:       gain_one_nxt = cfg_data[GAIN_W-1:0];
        CFG_GAIN_TWO:       gain_two_nxt = cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_one_r <= '0;
      step_two_r <= '0;
      gain_one_r <= '0;
      gain_two_r <= '0;
    end else begin
      step_one_r <= step_one_nxt;
      step_two_r <= step_two_nxt;
      gain_one_r <= gain_one_nxt;
      gain_two_r <= gain_two_nxt;
    end
  end

  // pipeline handshake: each stage loads when empty or moving on
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, vo_r, vo_nxt;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic in_fire, out_fire, ld2, ld3, ldo;

  assign rdy_o     = !vo_r || out_tready;
  assign rdy3      = !v3_r || rdy_o;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign in_fire   = in_tvalid && rdy1;
  assign out_fire  = vo_r && out_tready;
  assign ld2       = v1_r && rdy2;
  assign ld3       = v2_r && rdy3;
  assign ldo       = v3_r && rdy_o;

  always_comb begin
    v1_nxt = rdy1  ? in_tvalid : v1_r;
    v2_nxt = rdy2  ? v1_r      : v2_r;
    v3_nxt = rdy3  ? v2_r      : v3_r;
    vo_nxt = rdy_o ? v3_r      : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  // stage 1: phase read, advance and write-back
  logic          in_ch;
  logic          in_oor;
  logic          oor1_r;
  dsom_ph_ctl_t  ph_ctl;
  logic [PW-1:0] ph_one;
  logic [PW-1:0] ph_two;

  assign in_ch         = in_tdata[0];
  assign in_oor        = 32'(in_ch) >= CHANNELS;
  assign ph_ctl.load   = in_fire;
  assign ph_ctl.commit = ld2 && !oor1_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      oor1_r <= in_oor;
    end
  end

  dsom_phase_acc #(
    .CHANNELS   (CHANNELS),
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ph_ctl),
    .channel        (in_ch),
    .phase_step_one (step_one_r),
    .phase_step_two (step_two_r),
    .phase_one      (ph_one),
    .phase_two      (ph_two)
  );

  // stage 2: quadrant split and table read
  logic [AW+1:0]       idx_one, idx_two;
  logic [AW-1:0]       taddr_one, taddr_two;
  logic [SAMPLE_W-1:0] tq_one, tq_two;
  logic                neg_one_r, neg_two_r, oor2_r;

  assign idx_one   = ph_one[PW-1 -: AW+2];
  assign idx_two   = ph_two[PW-1 -: AW+2];
  // odd quadrants run the table backward
  assign taddr_one = idx_one[AW] ? ~idx_one[AW-1:0] : idx_one[AW-1:0];
  assign taddr_two = idx_two[AW] ? ~idx_two[AW-1:0] : idx_two[AW-1:0];

  dsom_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .en     (ld2),
    .addr_a (taddr_one),
    .addr_b (taddr_two),
    .q_a    (tq_one),
    .q_b    (tq_two)
  );

  always_ff @(posedge clk) begin
    if (ld2) begin
      neg_one_r <= idx_one[AW+1];
      neg_two_r <= idx_two[AW+1];
      oor2_r    <= oor1_r;
    end
  end

  // stage 3: sign and gain
  logic signed [SAMPLE_W:0]     sin_one, sin_two;
  logic signed [2*SAMPLE_W+1:0] prod_one_r, prod_two_r;
  logic                         oor3_r;

  assign sin_one = neg_one_r ? -$signed({1'b0, tq_one}) : $signed({1'b0, tq_one});
  assign sin_two = neg_two_r ? -$signed({1'b0, tq_two}) : $signed({1'b0, tq_two});

  always_ff @(posedge clk) begin
    if (ld3) begin
      prod_one_r <= sin_one * $signed({1'b0, gain_one_r});
      prod_two_r <= sin_two * $signed({1'b0, gain_two_r});
      oor3_r     <= oor2_r;
    end
  end

  // stage 4: sum, round half up to Q1.15, saturate
  logic signed [2*SAMPLE_W+2:0] sum;
  logic signed [2*SAMPLE_W+3:0] biased;
  logic signed [20:0]           rnd;
  logic [SAMPLE_W-1:0]          sat;
  logic                         clip;
  logic [SAMPLE_W-1:0]          sample_r;
  logic                         clip_r;

  assign sum    = (2*SAMPLE_W+3)'(prod_one_r) + (2*SAMPLE_W+3)'(prod_two_r);
  assign biased = (2*SAMPLE_W+4)'(sum) + 36'sd16384;
  assign rnd    = 21'(biased >>> 15);

  always_comb begin
    sat  = rnd[SAMPLE_W-1:0];
    clip = 1'b0;
    if (rnd > 21'sd32767) begin
      sat  = 16'h7fff;
      clip = 1'b1;
    end else if (rnd < -21'sd32768) begin
      sat  = 16'h8000;
      clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ldo) begin
      sample_r <= oor3_r ? '0 : sat;
      clip_r   <= oor3_r ? 1'b0 : clip;
    end
  end

  assign out_tvalid   = vo_r;
  assign out_tdata    = sample_r;
  assign out_tuser[0] = clip_r;

  logic [2:0] occ;
  assign occ = 3'($countones({v1_r, v2_r, v3_r, vo_r}));

  `DSOM_ASSERT(a_occ_up, (in_fire && !out_fire) |=> occ == $past(occ) + 3'd1, "beat lost or invented on accept")
  `DSOM_ASSERT(a_occ_down, (out_fire && !in_fire) |=> occ == $past(occ) - 3'd1, "beat lost or invented on delivery")
  `DSOM_ASSERT(a_clip_at_rail, (vo_r && clip_r) |-> (sample_r == 16'h7fff || sample_r == 16'h8000), "clipped sample not at rail")

endmodule

>>> tb/tb_dual_sine_oscillator_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_sine_oscillator_mixer
// Self-checking bench for the two-tone sine mixer. A scoreboard keeps its own
// per-channel phase pairs, quarter-wave table and register copies, predicts
// each sample with its clip flag, and compares the output beats in order.
// A directed part hits zero gains, both channels, all quadrants, over-unity
// gains with saturation of either sign, and a write to an unused register index.
// Random phases then reprogram all registers and stream random channel requests
// under random backpressure, one long output hold and a mid-phase drain.
// ----------------------------------------------------------------------------
module tb_dual_sine_oscillator_mixer;

  localparam int TABLE_DEPTH = dsom_pkg::SINE_TABLE_DEPTH_DEF;
  localparam int PHASE_W     = dsom_pkg::PHASE_BITS_DEF;
  localparam int RANDOM_REQS = 1750;
  localparam int HOLD_CYCLES = 300;
  localparam bit [63:0] PI_Q30  = 64'd3373259426;
  localparam bit [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [dsom_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;

  typedef struct packed {
    logic [dsom_pkg::SAMPLE_W-1:0] sample;
    logic                          clipped;
  } mix_sample_t;

  class mix_scoreboard;
    bit [15:0]        quarter_wave [TABLE_DEPTH];
    bit [PHASE_W-1:0] phase_one [dsom_pkg::CHANNELS_DEF];
    bit [PHASE_W-1:0] phase_two [dsom_pkg::CHANNELS_DEF];
    bit [31:0]        step_one, step_two;
    bit [15:0]        gain_one, gain_two;
    mix_sample_t      expected_samples [$];
    int               errors;

    function new();
      bit [63:0] divs [6];
      bit [63:0] x, sq, acc, s;
      divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        x = ((64'd2 * i + 64'd1) * PI_Q30) / (64'd4 * TABLE_DEPTH);
        sq = (x * x) >> 30;
        acc = Q30_ONE;
        for (int k = 0; k < 6; k++)
          acc = Q30_ONE - ((sq * acc) >> 30) / divs[k];
        s = (x * acc) >> 30;
        quarter_wave[i] = 16'((s * 64'd32767 + (64'd1 << 29)) >> 30);
      end
      foreach (phase_one[c]) begin
        phase_one[c] = '0;
        phase_two[c] = '0;
      end
      step_one = '0;
      step_two = '0;
      gain_one = '0;
      gain_two = '0;
      errors   = 0;
    endfunction

    function void set_register(logic [dsom_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        dsom_pkg::CFG_PHASE_STEP_ONE: step_one = val;
        dsom_pkg::CFG_PHASE_STEP_TWO: step_two = val;
        dsom_pkg::CFG_GAIN_ONE:       gain_one = val[15:0];
        dsom_pkg::CFG_GAIN_TWO:       gain_two = val[15:0];
        default: ;
      endcase
    endfunction

    function int sine_of(bit [PHASE_W-1:0] ph);
      bit [63:0]   idx;
      int unsigned quad, off;
      idx  = ({{(64-PHASE_W){1'b0}}, ph} * (64'd4 * TABLE_DEPTH)) >> PHASE_W;
      quad = int'((idx / TABLE_DEPTH) & 64'd3);
      off  = int'(idx % TABLE_DEPTH);
      if (quad[0]) off = TABLE_DEPTH - 1 - off;
      return quad[1] ? -int'(quarter_wave[off]) : int'(quarter_wave[off]);
    endfunction

    function void note_request(bit ch);
      longint      sum, rounded;
      mix_sample_t s;
      sum = longint'(sine_of(phase_one[ch])) * longint'(gain_one)
          + longint'(sine_of(phase_two[ch])) * longint'(gain_two);
      rounded = (sum + 64'sd16384) >>> 15;
      s.clipped = 1'b0;
      if (rounded > 32767) begin
        rounded = 32767;
        s.clipped = 1'b1;
      end else if (rounded < -32768) begin
        rounded = -32768;
        s.clipped = 1'b1;
      end
      s.sample = rounded[15:0];
      expected_samples.push_back(s);
      phase_one[ch] = phase_one[ch] + step_one;
      phase_two[ch] = phase_two[ch] + step_two;
    endfunction

    function void check_sample(logic [dsom_pkg::SAMPLE_W-1:0] sample, logic clipped);
      mix_sample_t want;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected beat: sample %h clipped %b", $realtime, sample, clipped);
        return;
      end
      want = expected_samples.pop_front();
      if (sample !== want.sample || clipped !== want.clipped) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: sample exp %h got %h, clipped exp %b got %b",
                   $realtime, want.sample, sample, want.clipped, clipped);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [dsom_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [dsom_pkg::SAMPLE_W-1:0]    out_tdata;
  logic [0:0]                       out_tuser;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [dsom_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [dsom_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  bit            idle_on       = 1'b1;
  bit            stall_request = 1'b0;
  mix_scoreboard board;

  dual_sine_oscillator_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("tb_dual_sine_oscillator_mixer failed");
    $finish;
  end

  // leaves in_tvalid high, apart from a random idle gap, so back-to-back beats need no extra edge
  task automatic send_request(input bit ch);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(dsom_pkg::IN_TDATA_W-1){1'b0}}, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(ch);
    if (idle_on && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic stop_requests();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(input logic [dsom_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, val);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 1 << 20));  // slow tone
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd32768;
      2:       return 32'd65535;
      3:       return 32'($urandom_range(0, 65535));
      default: return 32'($urandom_range(0, 32768));
    endcase
  endfunction

  // output side: checks beats, random backpressure, one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        board.check_sample(out_tdata, out_tuser[0]);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(0, 99) < 6);
      end
    end
  end

  initial begin
    int sent;
    int round;
    int n;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero gains on both channels
    send_request(1'b0);
    send_request(1'b1);
    stop_requests();
    drain();

    // unity gains, quarter and eighth turn steps: all quadrants, positive clip
    write_reg(dsom_pkg::CFG_PHASE_STEP_ONE, 32'h4000_0000);
    write_reg(dsom_pkg::CFG_PHASE_STEP_TWO, 32'h2000_0000);
    write_reg(dsom_pkg::CFG_GAIN_ONE, 32'd32768);
    write_reg(dsom_pkg::CFG_GAIN_TWO, 32'd32768);
    end_writes();
    repeat (8) send_request(1'b0);
    repeat (2) send_request(1'b1);
    stop_requests();
    drain();

    // full-scale gains above unity, backward steps: negative clip, phase wrap
    write_reg(dsom_pkg::CFG_PHASE_STEP_ONE, 32'hC000_0000);
    write_reg(dsom_pkg::CFG_PHASE_STEP_TWO, 32'hFFFF_FFFF);
    write_reg(dsom_pkg::CFG_GAIN_ONE, 32'd65535);
    write_reg(dsom_pkg::CFG_GAIN_TWO, 32'd65535);
    write_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);  // ignored index
    end_writes();
    for (int i = 0; i < 6; i++) send_request(i[0]);
    stop_requests();
    drain();

    sent  = 0;
    round = 0;
    while (sent < RANDOM_REQS) begin
      write_reg(dsom_pkg::CFG_PHASE_STEP_ONE, pick_step());
      write_reg(dsom_pkg::CFG_PHASE_STEP_TWO, pick_step());
      write_reg(dsom_pkg::CFG_GAIN_ONE, pick_gain());
      write_reg(dsom_pkg::CFG_GAIN_TWO, pick_gain());
      end_writes();
      n = $urandom_range(80, 220);
      if (n > RANDOM_REQS - sent) n = RANDOM_REQS - sent;
      idle_on = (round != 2);
      for (int i = 0; i < n; i++) begin
        if (round == 1 && i == 40) stall_request = 1'b1;
        if (round == 3 && i == n / 2) begin
          stop_requests();
          drain();
        end
        send_request(1'($urandom_range(0, 1)));
      end
      stop_requests();
      drain();
      idle_on = 1'b1;
      sent += n;
      round++;
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("tb_dual_sine_oscillator_mixer passed");
    else
      $display("tb_dual_sine_oscillator_mixer failed");
    $finish;
  end

endmodule
